### src/rgbled_pkg.sv
package rgbled_pkg;

  localparam int BITS_PER_PIXEL = 24;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_SETPX = 2'd1;
  localparam logic [1:0] CMD_BLACK = 2'd2;
  localparam logic [1:0] CMD_START = 2'd3;

  localparam logic [1:0] REG_BIT_PERIOD = 2'd0;
  localparam logic [1:0] REG_ZERO_HIGH  = 2'd1;
  localparam logic [1:0] REG_ONE_HIGH   = 2'd2;

  localparam logic [15:0] BIT_PERIOD_RST = 16'd124;
  localparam logic [15:0] ZERO_HIGH_RST  = 16'd40;
  localparam logic [15:0] ONE_HIGH_RST   = 16'd80;

  localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
  localparam logic [23:0] COLOR_BLACK = 24'h000000;

  typedef struct packed {
    logic        tick;
    logic        start;
    logic [9:0]  count;
    logic [23:0] word;
  } tmr_ctl_t;

  typedef struct packed {
    logic line;
    logic busy;
    logic done;
  } tmr_stat_t;

  typedef struct packed {
    logic [15:0] bit_period;
    logic [15:0] zero_high;
    logic [15:0] one_high;
  } tmr_cfg_t;

endpackage

### src/rgbled_pixel_ram.sv
module rgbled_pixel_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [DEPTH];
  logic [23:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/rgbled_bit_timer.sv
module rgbled_bit_timer #(
  parameter int MAX_PIXELS = 512,
  parameter int AW         = 9
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rgbled_pkg::tmr_cfg_t cfg,
  input  rgbled_pkg::tmr_ctl_t ctl,
  output rgbled_pkg::tmr_stat_t stat,
  output logic                 frame_busy,
  output logic [AW-1:0]        rd_addr
);

  localparam int FRAME = MAX_PIXELS * rgbled_pkg::BITS_PER_PIXEL + 1;
  localparam int PW    = $clog2(FRAME + 1);
  localparam int CW    = $clog2(MAX_PIXELS + 1);
  localparam logic [4:0] SEL_TOP = 5'(rgbled_pkg::BITS_PER_PIXEL - 1);

  logic          busy_r, busy_nxt;
  logic [15:0]   tick_r, tick_nxt;
  logic [PW-1:0] per_r, per_nxt;
  logic [PW-1:0] bits_r, bits_nxt;
  logic          bit_r, bit_nxt;
  logic          line_r, line_nxt;
  logic [4:0]    sel_r, sel_nxt;
  logic [CW-1:0] pix_r, pix_nxt;
  logic          done;
  logic          in_data;

  always_comb begin
    busy_nxt = busy_r;
    tick_nxt = tick_r;
    per_nxt  = per_r;
    bits_nxt = bits_r;
    bit_nxt  = bit_r;
    line_nxt = line_r;
    sel_nxt  = sel_r;
    pix_nxt  = pix_r;
    done     = 1'b0;
    in_data  = 1'b0;
    if (ctl.start) begin
      busy_nxt = 1'b1;
      tick_nxt = '0;
      per_nxt  = '0;
      bits_nxt = PW'(32'(ctl.count) * rgbled_pkg::BITS_PER_PIXEL);
      bit_nxt  = 1'b0;
      line_nxt = 1'b0;
      sel_nxt  = SEL_TOP;
      pix_nxt  = '0;
    end else if (ctl.tick && busy_r) begin
      tick_nxt = (tick_r == cfg.bit_period) ? '0 : tick_r + 16'd1;
      if (tick_nxt == 16'd1) begin
        per_nxt = per_r + PW'(1);
        if (per_nxt <= bits_r) begin
          bit_nxt  = ctl.word[sel_r];
          line_nxt = 1'b1;
          if (sel_r == 5'd0) begin
            sel_nxt = SEL_TOP;
            pix_nxt = pix_r + CW'(1);
          end else begin
            sel_nxt = sel_r - 5'd1;
          end
        end
        if (per_nxt >= PW'(FRAME)) begin
          line_nxt = 1'b0;
          busy_nxt = 1'b0;
          done     = 1'b1;
        end
      end
      if (busy_nxt) begin
        in_data = (per_nxt != '0) && (per_nxt <= bits_r);
        if (in_data && tick_nxt == cfg.zero_high && !bit_nxt) begin
          line_nxt = 1'b0;
        end
        if (in_data && tick_nxt == cfg.one_high) begin
          line_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tick_r <= '0;
      per_r  <= '0;
      bits_r <= '0;
      bit_r  <= 1'b0;
      line_r <= 1'b0;
      sel_r  <= SEL_TOP;
      pix_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      tick_r <= tick_nxt;
      per_r  <= per_nxt;
      bits_r <= bits_nxt;
      bit_r  <= bit_nxt;
      line_r <= line_nxt;
      sel_r  <= sel_nxt;
      pix_r  <= pix_nxt;
    end
  end

  assign stat.line  = line_nxt;
  assign stat.busy  = busy_nxt;
  assign stat.done  = done;
  assign frame_busy = busy_r;
  assign rd_addr    = pix_r[AW-1:0];

endmodule

### src/rgb_led_serial_frame_driver_core.sv
// channel | direction | handshake            | payload
// in_     | input     | in_tvalid/in_tready   | tuser command, tdata index/color/count
// out_    | output    | out_tvalid/out_tready | tdata line/busy/done/error
// cfg_    | input     | cfg_valid/cfg_ready   | cfg_index, cfg_data
//
// each word is accepted with a pixel ram read, then updated with its result; no new word is taken meanwhile
// a blackout of n pixels holds in_tready low while it writes black to pixels 0 to n-1
// after reset a clearing pass fills all MAX_PIXELS ram words with white
// a result waiting in the output register stalls the update cycle, not the accept
// cfg_ready is always high; rst_n is synchronous, active low
module rgb_led_serial_frame_driver_core #(
  parameter int MAX_PIXELS = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // pixel_index[8:0], red, green, blue, pixel_count, zero pad
  input  logic [1:0]  in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // line_level, busy_res, frame_done, request_error, zero pad
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int AW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int CW = $clog2(MAX_PIXELS + 1);
  localparam logic [CW-1:0] SW_LAST = CW'(MAX_PIXELS - 1);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EXEC  = 2'd2;
  localparam logic [1:0] ST_BLACK = 2'd3;

  logic [1:0]    state_r, state_nxt;
  logic [CW-1:0] sw_r, sw_nxt;
  logic [CW-1:0] lim_r, lim_nxt;
  logic [1:0]    cmd_r;
  logic [8:0]    idx_r;
  logic [23:0]   color_r;
  logic [9:0]    cnt_r;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_data_r, out_data_nxt;

  rgbled_pkg::tmr_cfg_t  cfg_r;
  rgbled_pkg::tmr_ctl_t  ctl;
  rgbled_pkg::tmr_stat_t stat;

  logic          accept;
  logic          step;
  logic          err;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [23:0]   ram_wdata;
  logic [AW-1:0] tmr_addr;
  logic [23:0]   ram_rdata;
  logic          tmr_busy;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign step      = (state_r == ST_EXEC) && (!out_valid_r || out_tready);
  assign cfg_ready = 1'b1;

  always_comb begin
    unique case (cmd_r)
      rgbled_pkg::CMD_TICK:  err = 1'b0;
      rgbled_pkg::CMD_SETPX: err = (32'(idx_r) >= MAX_PIXELS);
      rgbled_pkg::CMD_BLACK: err = (32'(cnt_r) > MAX_PIXELS);
      rgbled_pkg::CMD_START: err = (32'(cnt_r) > MAX_PIXELS) || tmr_busy;
    endcase
  end

  always_comb begin
    ctl.tick  = step && (cmd_r == rgbled_pkg::CMD_TICK);
    ctl.start = step && (cmd_r == rgbled_pkg::CMD_START) && !err;
    ctl.count = cnt_r;
    ctl.word  = ram_rdata;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sw_r[AW-1:0];
    ram_wdata = rgbled_pkg::COLOR_BLACK;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = rgbled_pkg::COLOR_WHITE;
      end
      ST_BLACK: begin
        ram_we = 1'b1;
      end
      ST_EXEC: begin
        if (step && cmd_r == rgbled_pkg::CMD_SETPX && !err) begin
          ram_we    = 1'b1;
          ram_waddr = AW'(idx_r);
          ram_wdata = color_r;
        end
      end
      ST_IDLE: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    sw_nxt    = sw_r;
    lim_nxt   = lim_r;
    unique case (state_r)
      ST_CLEAR: begin
        sw_nxt = sw_r + CW'(1);
        if (sw_r == SW_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (step) begin
          if (cmd_r == rgbled_pkg::CMD_BLACK && !err && cnt_r != 10'd0) begin
            state_nxt = ST_BLACK;
            sw_nxt    = '0;
            lim_nxt   = CW'(cnt_r - 10'd1);
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_BLACK: begin
        sw_nxt = sw_r + CW'(1);
        if (sw_r == lim_r) begin
          state_nxt = ST_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (step) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = {4'd0, err, stat.done, stat.busy, stat.line};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      sw_r        <= '0;
      lim_r       <= '0;
      out_valid_r <= 1'b0;
      cfg_r.bit_period <= rgbled_pkg::BIT_PERIOD_RST;
      cfg_r.zero_high  <= rgbled_pkg::ZERO_HIGH_RST;
      cfg_r.one_high   <= rgbled_pkg::ONE_HIGH_RST;
    end else begin
      state_r     <= state_nxt;
      sw_r        <= sw_nxt;
      lim_r       <= lim_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          rgbled_pkg::REG_BIT_PERIOD: cfg_r.bit_period <= cfg_data;
          rgbled_pkg::REG_ZERO_HIGH:  cfg_r.zero_high  <= cfg_data;
          rgbled_pkg::REG_ONE_HIGH:   cfg_r.one_high   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (accept) begin
      cmd_r   <= in_tuser;
      idx_r   <= in_tdata[8:0];
      color_r <= {in_tdata[24:17], in_tdata[16:9], in_tdata[32:25]};
      cnt_r   <= in_tdata[42:33];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  rgbled_pixel_ram #(
    .DEPTH (MAX_PIXELS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept),
    .raddr (tmr_addr),
    .rdata (ram_rdata)
  );

  rgbled_bit_timer #(
    .MAX_PIXELS (MAX_PIXELS),
    .AW         (AW)
  ) u_tmr (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .ctl        (ctl),
    .stat       (stat),
    .frame_busy (tmr_busy),
    .rd_addr    (tmr_addr)
  );

endmodule

### src/rgbled_checker.sv
module rgbled_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result word dropped while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input ready during ram clearing pass");

  a_two_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("word accepted while previous one still in update");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> !out_tdata[1] && !out_tdata[0] && !out_tdata[3])
    else $error("frame end with busy, line high or error");

endmodule

bind rgb_led_serial_frame_driver_core rgbled_checker u_rgbled_checker (.*);
